@@ rtl/core/plrsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrsc_pkg: shared types and constants for the pinned LRU region slot cache
// Commands, status codes, cell control and cell report structs.
// ----------------------------------------------------------------------------
package plrsc_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 5;
	localparam int KEY_W   = 48;
	localparam int STAMP_W = 64;
	localparam int BATCH_W = 32;

	typedef enum logic [2:0] {
		CMD_ALLOCATE    = 3'd0,
		CMD_UPLOAD      = 3'd1,
		CMD_TOUCH_KEY   = 3'd2,
		CMD_TOUCH_BATCH = 3'd3,
		CMD_LOOKUP      = 3'd4,
		CMD_CLEAR       = 3'd5
	} cmd_t;

	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_NEW      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [7:0] REG_SLOTS_IN_USE = 8'd0;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic               upd_hit;    // update the hit cell
		logic               upd_batch;  // restamp cells whose tag matches
		logic               wr_new;     // write a new entry into wr_slot
		logic [SLOT_W-1:0]  wr_slot;
		logic               set_batch;  // hit: overwrite batch tag
		logic               set_dirty;  // hit: or dirty
		logic               set_pres;   // hit: set present
		logic               new_pres;
		logic               new_dirty;
		logic [STAMP_W-1:0] stamp;
		logic [KEY_W-1:0]   key;
		logic [BATCH_W-1:0] batch;
	} cell_ctl_t;

	// Running victim search handed from cell to cell.
	typedef struct packed {
		logic               found;
		logic [SLOT_W-1:0]  idx;
		logic [STAMP_W-1:0] stamp;
	} vict_t;

endpackage

@@ rtl/core/plrsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrsc_req_if / plrsc_rsp_if: valid/ready channels of the slot cache
// Request channel carries one command item, response channel one result.
// ----------------------------------------------------------------------------
interface plrsc_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [15:0] key_x;
	logic signed [15:0] key_y;
	logic signed [15:0] key_z;
	logic [31:0]        batch_marker;
	logic               allow_create;
	logic               force_upload;
	logic               skip_download;
	logic               region_exists;
	modport source (output valid, command, key_x, key_y, key_z, batch_marker,
		allow_create, force_upload, skip_download, region_exists, input ready);
	modport sink (input valid, command, key_x, key_y, key_z, batch_marker,
		allow_create, force_upload, skip_download, region_exists, output ready);
endinterface

interface plrsc_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         slot;
	logic               region_present;
	logic               create_region;
	logic               write_to_gpu;
	logic               blank_fill;
	logic               write_back;
	logic signed [15:0] victim_x;
	logic signed [15:0] victim_y;
	logic signed [15:0] victim_z;
	modport source (output valid, status, slot, region_present, create_region,
		write_to_gpu, blank_fill, write_back, victim_x, victim_y, victim_z,
		input ready);
	modport sink (input valid, status, slot, region_present, create_region,
		write_to_gpu, blank_fill, write_back, victim_x, victim_y, victim_z,
		output ready);
endinterface

@@ rtl/core/plrsc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrsc_cell: one cache slot
// Holds key, stamp, batch tag and marks; compares the key and folds itself
// into the victim search, which moves one cell per cycle along the chain.
// ----------------------------------------------------------------------------
module plrsc_cell import plrsc_pkg::*; (
	input  logic               clk,
	input  logic [SLOT_W-1:0]  idx,
	input  logic               valid,      // slot below fill count
	input  logic [KEY_W-1:0]   key,
	input  logic [BATCH_W-1:0] bm,
	input  cell_ctl_t          ctl,
	input  logic               hit_sel,    // this cell is the chosen hit
	input  vict_t              vin,
	output vict_t              vout,
	output logic               match,
	output logic [KEY_W-1:0]   key_o,
	output logic               pres_o,
	output logic               dirty_o
);

	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [BATCH_W-1:0] batch_q;
	logic               pres_q;
	logic               dirty_q;
	logic               pinned;
	vict_t              vnext;
	vict_t              vout_q;

	assign match   = valid && (key_q == key);
	assign key_o   = key_q;
	assign pres_o  = pres_q;
	assign dirty_o = dirty_q;
	assign pinned  = (bm != '0) && (batch_q == bm);
	assign vout    = vout_q;

	// Keep the older unpinned candidate; earlier cells win ties.
	always_comb begin
		vnext = vin;
		if (valid && !pinned && (!vin.found || stamp_q < vin.stamp)) begin
			vnext.found = 1'b1;
			vnext.idx   = idx;
			vnext.stamp = stamp_q;
		end
	end

	// Hand the running candidate to the next cell.
	always_ff @(posedge clk) begin
		vout_q <= vnext;
	end

	// Update the slot contents.
	always_ff @(posedge clk) begin
		if (ctl.wr_new && ctl.wr_slot == idx) begin
			key_q   <= ctl.key;
			stamp_q <= ctl.stamp;
			batch_q <= ctl.batch;
			pres_q  <= ctl.new_pres;
			dirty_q <= ctl.new_dirty;
		end else if (ctl.upd_hit && hit_sel) begin
			stamp_q <= ctl.stamp;
			if (ctl.set_batch) batch_q <= ctl.batch;
			if (ctl.set_dirty) dirty_q <= 1'b1;
			if (ctl.set_pres)  pres_q  <= 1'b1;
		end else if (ctl.upd_batch && valid && batch_q == ctl.batch) begin
			stamp_q <= ctl.stamp;
		end
	end

endmodule

@@ rtl/core/pinned_lru_region_slot_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_lru_region_slot_cache: fully associative LRU slot cache with pinning
// Sixteen slot cells in a chain with a small sequencer and APB register.
// ----------------------------------------------------------------------------
// After a request transfer the sequencer steps through S_MATCH, in which every
// cell compares its key and the oldest-unpinned victim search moves one cell per
// cycle down the cell chain, S_UPDATE, which updates the chosen cell and loads
// the result register, and S_OUT, in which the result is offered. A new request
// is taken the cycle after the result transfer, so the chain serves one request
// at a time. Register 0 (slots_in_use) is at address 0.
module pinned_lru_region_slot_cache import plrsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	plrsc_req_if.sink   req,
	plrsc_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_MATCH, S_UPDATE, S_OUT} state_t;

	state_t             state_q;
	logic [4:0]         slots_q;
	logic [CNT_W-1:0]   fill_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [SLOT_W-1:0]  scan_q;

	logic [2:0]         cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [BATCH_W-1:0] bm_q;
	logic               create_q, force_q, skip_q, exists_q;

	logic               hit_s2;
	logic [SLOT_W-1:0]  hit_idx_s2;
	vict_t              vict_end;

	cell_ctl_t          ctl;
	vict_t              chain [SLOTS+1];
	logic [SLOTS-1:0]   match_v, pres_v, dirty_v, hit_sel;
	logic [KEY_W-1:0]   key_v [SLOTS];
	logic               hit_c;
	logic [SLOT_W-1:0]  hit_idx_c;
	logic [CNT_W-1:0]   cap;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_SLOTS_IN_USE[0:0]) ? {27'd0, slots_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 5'd16;
		end else if (psel && penable && pwrite && paddr == REG_SLOTS_IN_USE[0:0]) begin
			slots_q <= pwdata[4:0];
		end
	end

	assign cap = (slots_q == 5'd0) ? 5'd1 : (slots_q > 5'(SLOTS)) ? 5'(SLOTS) : slots_q;

	// Cell chain.
	assign chain[0] = '0;
	assign vict_end = chain[SLOTS];
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			plrsc_cell u_cell (
				.clk    (clk),
				.idx    (SLOT_W'(g)),
				.valid  (5'(g) < fill_q),
				.key    (key_q),
				.bm     (bm_q),
				.ctl    (ctl),
				.hit_sel(hit_sel[g]),
				.vin    (chain[g]),
				.vout   (chain[g+1]),
				.match  (match_v[g]),
				.key_o  (key_v[g]),
				.pres_o (pres_v[g]),
				.dirty_o(dirty_v[g])
			);
			assign hit_sel[g] = (hit_idx_s2 == SLOT_W'(g));
		end
	endgenerate

	// Lowest matching slot.
	always_comb begin
		hit_c = 1'b0;
		hit_idx_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_v[i]) begin
				hit_c = 1'b1;
				hit_idx_c = SLOT_W'(i);
			end
		end
	end

	// Decide the update and result for the registered match.
	logic               is_up, room, hp, linked, gpu, npres;
	logic [1:0]         st;
	logic [SLOT_W-1:0]  sl;
	logic               r_pres, r_cre, r_gpu, r_blank, r_wb;
	logic [KEY_W-1:0]   r_vkey;
	always_comb begin
		is_up  = (cmd_q == CMD_UPLOAD);
		room   = fill_q < cap;
		hp     = pres_v[hit_idx_s2];
		linked = !hp && create_q;
		gpu    = is_up && (force_q || linked);
		npres  = exists_q || create_q;
		ctl = '0;
		ctl.stamp = stamp_q;
		ctl.key   = key_q;
		ctl.batch = bm_q;
		ctl.new_pres  = npres;
		ctl.new_dirty = !skip_q;
		ctl.set_batch = bm_q != '0;
		ctl.set_dirty = !skip_q;
		ctl.set_pres  = linked;
		st = ST_NOTFOUND; sl = '0; r_pres = 1'b0; r_cre = 1'b0; r_gpu = 1'b0;
		r_blank = 1'b0; r_wb = 1'b0; r_vkey = '0;
		if (state_q == S_UPDATE) begin
			unique case (cmd_q)
				CMD_ALLOCATE, CMD_UPLOAD: begin
					if (hit_s2) begin
						ctl.upd_hit = 1'b1;
						st = ST_HIT; sl = hit_idx_s2;
						r_pres = hp || linked;
						r_cre = linked && !exists_q;
						r_gpu = gpu;
						r_blank = gpu && !(hp || linked);
					end else if (room || vict_end.found) begin
						ctl.wr_new = 1'b1;
						ctl.wr_slot = room ? fill_q[SLOT_W-1:0] : vict_end.idx;
						st = ST_NEW; sl = ctl.wr_slot;
						r_pres = npres; r_cre = create_q && !exists_q;
						r_gpu = is_up; r_blank = is_up && !npres;
						if (!room && pres_v[vict_end.idx] && dirty_v[vict_end.idx]) begin
							r_wb = 1'b1;
							r_vkey = key_v[vict_end.idx];
						end
					end else begin
						st = ST_FULL;
						r_pres = npres; r_cre = create_q && !exists_q;
					end
				end
				CMD_TOUCH_KEY, CMD_LOOKUP: begin
					if (hit_s2) begin
						ctl.upd_hit = (cmd_q == CMD_TOUCH_KEY);
						ctl.set_batch = 1'b0; ctl.set_dirty = 1'b0; ctl.set_pres = 1'b0;
						st = ST_HIT; sl = hit_idx_s2; r_pres = hp;
					end
				end
				CMD_TOUCH_BATCH: begin
					ctl.upd_batch = 1'b1;
					st = ST_HIT;
				end
				CMD_CLEAR: st = ST_HIT;
				default: st = ST_NOTFOUND;
			endcase
		end
	end

	logic new_fill;
	assign new_fill = ctl.wr_new && room;

	// Sequencer, counters and result register.
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			stamp_q <= '0;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					state_q <= S_MATCH;
					scan_q  <= '0;
				end
				S_MATCH: begin
					// Hold until the victim search has passed every cell.
					scan_q <= scan_q + 1'b1;
					if (scan_q == SLOT_W'(SLOTS - 1)) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_OUT;
					if (ctl.upd_hit || ctl.wr_new || ctl.upd_batch) stamp_q <= stamp_q + 1'b1;
					if (new_fill) fill_q <= fill_q + 1'b1;
					if (cmd_q == CMD_CLEAR) fill_q <= '0;
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q    <= req.command;
			key_q    <= {req.key_z, req.key_y, req.key_x};
			bm_q     <= req.batch_marker;
			create_q <= req.allow_create;
			force_q  <= req.force_upload;
			skip_q   <= req.skip_download;
			exists_q <= req.region_exists;
		end
		if (state_q == S_MATCH) begin
			hit_s2     <= hit_c;
			hit_idx_s2 <= hit_idx_c;
		end
		if (state_q == S_UPDATE) begin
			rsp.status         <= st;
			rsp.slot           <= sl;
			rsp.region_present <= r_pres;
			rsp.create_region  <= r_cre;
			rsp.write_to_gpu   <= r_gpu;
			rsp.blank_fill     <= r_blank;
			rsp.write_back     <= r_wb;
			rsp.victim_x       <= r_vkey[15:0];
			rsp.victim_y       <= r_vkey[31:16];
			rsp.victim_z       <= r_vkey[47:32];
		end
	end

	// Checks.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'(SLOTS)) else $error("fill count beyond slot count");
	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid) else $error("request taken with result pending");
	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_UPDATE |=> stamp_q == $past(stamp_q))
		else $error("stamp moved outside update");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.upd_hit, ctl.wr_new, ctl.upd_batch}))
		else $error("conflicting cell updates");

endmodule
